FILE: sv/ple_pkg.sv
`default_nettype none

package ple_pkg;

  localparam int CAPACITY  = 64;
  localparam int SLOT_BITS = $clog2(CAPACITY);
  localparam int ELEM_BITS = 8;
  localparam int CNT_BITS  = 7;
  localparam int STEP_BITS = 4;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_LOCATE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]           command;
    logic [CNT_BITS-1:0]  position;
    logic [ELEM_BITS-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                 ok;
    logic [ELEM_BITS-1:0] element;
    logic [CNT_BITS-1:0]  found_position;
    logic [CNT_BITS-1:0]  length;
    logic                 empty_res;
  } rsp_t;

  // program steps
  localparam logic [STEP_BITS-1:0] S_IDLE       = 4'd0;
  localparam logic [STEP_BITS-1:0] S_DISP       = 4'd1;
  localparam logic [STEP_BITS-1:0] S_INS_HEAD   = 4'd2;
  localparam logic [STEP_BITS-1:0] S_INS_WALK   = 4'd3;
  localparam logic [STEP_BITS-1:0] S_INS_SPLICE = 4'd4;
  localparam logic [STEP_BITS-1:0] S_DEL_WALK   = 4'd5;
  localparam logic [STEP_BITS-1:0] S_GET_WALK   = 4'd6;
  localparam logic [STEP_BITS-1:0] S_LOC_WALK   = 4'd7;
  localparam logic [STEP_BITS-1:0] S_CLEAR      = 4'd8;
  localparam logic [STEP_BITS-1:0] S_DONE       = 4'd9;

  // jump conditions
  localparam logic [1:0] C_ALWAYS   = 2'd0;
  localparam logic [1:0] C_START    = 2'd1;
  localparam logic [1:0] C_AT_END   = 2'd2;
  localparam logic [1:0] C_OUT_FREE = 2'd3;

  // datapath operations
  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_LOAD_FIRST = 4'd1;
  localparam logic [3:0] OP_INS_HEAD   = 4'd2;
  localparam logic [3:0] OP_INS_LINK   = 4'd3;
  localparam logic [3:0] OP_INS_SPLICE = 4'd4;
  localparam logic [3:0] OP_DEL        = 4'd5;
  localparam logic [3:0] OP_GET        = 4'd6;
  localparam logic [3:0] OP_LOC        = 4'd7;
  localparam logic [3:0] OP_CLEAR      = 4'd8;
  localparam logic [3:0] OP_EMIT       = 4'd9;

  // command classes for the dispatch jump
  localparam logic [2:0] K_FAIL     = 3'd0;
  localparam logic [2:0] K_INS_HEAD = 3'd1;
  localparam logic [2:0] K_INS_MID  = 3'd2;
  localparam logic [2:0] K_DEL      = 3'd3;
  localparam logic [2:0] K_GET      = 3'd4;
  localparam logic [2:0] K_LOC      = 3'd5;
  localparam logic [2:0] K_CLEAR    = 3'd6;

  typedef struct packed {
    logic [1:0]           cond;
    logic [3:0]           op;
    logic                 hop;
    logic                 dispatch;
    logic [STEP_BITS-1:0] jump;
  } ucode_t;

  typedef struct packed {
    logic [3:0] op;
    logic       hop;
  } ctrl_t;

  typedef struct packed {
    logic       at_end;
    logic [2:0] cls;
  } status_t;

  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucode_t uw;
    unique case (step)
      S_IDLE:       uw = '{C_START,    OP_NONE,       1'b0, 1'b0, S_DISP};
      S_DISP:       uw = '{C_ALWAYS,   OP_LOAD_FIRST, 1'b0, 1'b1, S_DONE};
      S_INS_HEAD:   uw = '{C_ALWAYS,   OP_INS_HEAD,   1'b0, 1'b0, S_DONE};
      S_INS_WALK:   uw = '{C_AT_END,   OP_INS_LINK,   1'b1, 1'b0, S_INS_SPLICE};
      S_INS_SPLICE: uw = '{C_ALWAYS,   OP_INS_SPLICE, 1'b0, 1'b0, S_DONE};
      S_DEL_WALK:   uw = '{C_AT_END,   OP_DEL,        1'b1, 1'b0, S_DONE};
      S_GET_WALK:   uw = '{C_AT_END,   OP_GET,        1'b1, 1'b0, S_DONE};
      S_LOC_WALK:   uw = '{C_AT_END,   OP_LOC,        1'b1, 1'b0, S_DONE};
      S_CLEAR:      uw = '{C_ALWAYS,   OP_CLEAR,      1'b0, 1'b0, S_DONE};
      S_DONE:       uw = '{C_OUT_FREE, OP_EMIT,       1'b0, 1'b0, S_IDLE};
      default:      uw = '{C_ALWAYS,   OP_NONE,       1'b0, 1'b0, S_IDLE};
    endcase
    return uw;
  endfunction

  function automatic logic [STEP_BITS-1:0] dispatch_rom(input logic [2:0] cls);
    logic [STEP_BITS-1:0] s;
    unique case (cls)
      K_INS_HEAD: s = S_INS_HEAD;
      K_INS_MID:  s = S_INS_WALK;
      K_DEL:      s = S_DEL_WALK;
      K_GET:      s = S_GET_WALK;
      K_LOC:      s = S_LOC_WALK;
      K_CLEAR:    s = S_CLEAR;
      default:    s = S_DONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ple_seq.sv
`default_nettype none

module ple_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             out_free,
  input  wire ple_pkg::status_t status,
  output ple_pkg::ctrl_t        ctrl,
  output logic                  idle
);

  logic [ple_pkg::STEP_BITS-1:0] step;
  logic [ple_pkg::STEP_BITS-1:0] step_next;
  ple_pkg::ucode_t               uw;
  logic                          taken;

  always_comb begin
    uw = ple_pkg::ucode_rom(step);
    unique case (uw.cond)
      ple_pkg::C_ALWAYS:   taken = 1'b1;
      ple_pkg::C_START:    taken = start;
      ple_pkg::C_AT_END:   taken = status.at_end;
      ple_pkg::C_OUT_FREE: taken = out_free;
    endcase
    ctrl.op  = taken ? uw.op : ple_pkg::OP_NONE;
    ctrl.hop = !taken && uw.hop;
    if (!taken) begin
      step_next = step;
    end else if (uw.dispatch) begin
      step_next = ple_pkg::dispatch_rom(status.cls);
    end else begin
      step_next = uw.jump;
    end
  end

  assign idle = (step == ple_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ple_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ple_dp.sv
`default_nettype none

module ple_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire ple_pkg::cmd_t  cmd,
  input  wire ple_pkg::ctrl_t ctrl,
  output ple_pkg::status_t    status,
  output ple_pkg::rsp_t       res
);

  localparam int SB = ple_pkg::SLOT_BITS;
  localparam int CB = ple_pkg::CNT_BITS;
  localparam int EB = ple_pkg::ELEM_BITS;

  logic [EB-1:0] elem_mem   [ple_pkg::CAPACITY];
  logic [SB-1:0] link_mem   [ple_pkg::CAPACITY];
  logic [SB-1:0] fstack_mem [ple_pkg::CAPACITY];

  ple_pkg::cmd_t cmd_q;
  logic [SB-1:0] first;
  logic [CB-1:0] count;
  logic [CB-1:0] fill;
  logic [CB-1:0] ftop;
  logic [SB-1:0] cur;
  logic [SB-1:0] prev;
  logic [CB-1:0] idx;
  logic          ok;
  logic [EB-1:0] elem_r;
  logic [CB-1:0] found;

  logic [EB-1:0] elem_q;
  logic [SB-1:0] link_q;
  logic [SB-1:0] fs_q;

  logic [SB-1:0] rd_addr;
  logic [SB-1:0] fs_raddr;
  logic [SB-1:0] ns;
  logic          match;
  logic          lw_en;
  logic [SB-1:0] lw_addr;
  logic [SB-1:0] lw_data;
  logic          ew_en;
  logic          pos_one;

  assign match    = (elem_q == cmd_q.value);
  assign pos_one  = (cmd_q.position == CB'(1));
  assign fs_raddr = SB'(ftop - CB'(1));
  assign ns       = (ftop != '0) ? fs_q : fill[SB-1:0];

  always_comb begin
    if (ctrl.op == ple_pkg::OP_LOAD_FIRST) begin
      rd_addr = first;
    end else if (ctrl.hop) begin
      rd_addr = link_q;
    end else begin
      rd_addr = cur;
    end
  end

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = ns;
    lw_data = link_q;
    ew_en   = 1'b0;
    case (ctrl.op)
      ple_pkg::OP_INS_HEAD: begin
        lw_en   = 1'b1;
        lw_data = first;
        ew_en   = 1'b1;
      end
      ple_pkg::OP_INS_LINK: begin
        lw_en = 1'b1;
        ew_en = 1'b1;
      end
      ple_pkg::OP_INS_SPLICE: begin
        lw_en   = 1'b1;
        lw_addr = cur;
        lw_data = ns;
      end
      ple_pkg::OP_DEL: begin
        lw_en   = !pos_one;
        lw_addr = prev;
      end
      default: begin
      end
    endcase
  end

  // command class and walk end
  always_comb begin
    status.cls = ple_pkg::K_FAIL;
    unique case (cmd_q.command) inside
      ple_pkg::CMD_INSERT: begin
        if (count < CB'(ple_pkg::CAPACITY) && cmd_q.position != '0 &&
            cmd_q.position <= count + CB'(1)) begin
          status.cls = pos_one ? ple_pkg::K_INS_HEAD : ple_pkg::K_INS_MID;
        end
      end
      ple_pkg::CMD_DELETE: begin
        if (cmd_q.position != '0 && cmd_q.position <= count) begin
          status.cls = ple_pkg::K_DEL;
        end
      end
      ple_pkg::CMD_GET: begin
        if (cmd_q.position != '0 && cmd_q.position <= count) begin
          status.cls = ple_pkg::K_GET;
        end
      end
      ple_pkg::CMD_LOCATE: begin
        if (count != '0) begin
          status.cls = ple_pkg::K_LOC;
        end
      end
      ple_pkg::CMD_CLEAR: status.cls = ple_pkg::K_CLEAR;
      default: status.cls = ple_pkg::K_FAIL;
    endcase
  end

  always_comb begin
    unique case (cmd_q.command) inside
      ple_pkg::CMD_INSERT:                   status.at_end = (idx == cmd_q.position - CB'(1));
      ple_pkg::CMD_DELETE, ple_pkg::CMD_GET: status.at_end = (idx == cmd_q.position);
      ple_pkg::CMD_LOCATE:                   status.at_end = match || (idx == count);
      default:                               status.at_end = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (ew_en) begin
      elem_mem[ns] <= cmd_q.value;
    end
    if (ctrl.op == ple_pkg::OP_DEL) begin
      fstack_mem[ftop[SB-1:0]] <= cur;
    end
    link_q <= link_mem[rd_addr];
    elem_q <= elem_mem[rd_addr];
    fs_q   <= fstack_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= '0;
      count <= '0;
      fill  <= '0;
      ftop  <= '0;
    end else begin
      case (ctrl.op)
        ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_SPLICE: begin
          if (ctrl.op == ple_pkg::OP_INS_HEAD) begin
            first <= ns;
          end
          count <= count + CB'(1);
          if (ftop != '0) begin
            ftop <= ftop - CB'(1);
          end else begin
            fill <= fill + CB'(1);
          end
        end
        ple_pkg::OP_DEL: begin
          if (pos_one) begin
            first <= link_q;
          end
          count <= count - CB'(1);
          ftop  <= ftop + CB'(1);
        end
        ple_pkg::OP_CLEAR: begin
          first <= '0;
          count <= '0;
          fill  <= '0;
          ftop  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (ctrl.hop) begin
      prev <= cur;
      cur  <= link_q;
      idx  <= idx + CB'(1);
    end
    case (ctrl.op)
      ple_pkg::OP_LOAD_FIRST: begin
        cur    <= first;
        idx    <= CB'(1);
        ok     <= 1'b0;
        elem_r <= '0;
        found  <= '0;
      end
      ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_SPLICE, ple_pkg::OP_CLEAR: begin
        ok <= 1'b1;
      end
      ple_pkg::OP_DEL, ple_pkg::OP_GET: begin
        ok     <= 1'b1;
        elem_r <= elem_q;
      end
      ple_pkg::OP_LOC: begin
        ok    <= match;
        found <= match ? idx : '0;
      end
      default: begin
      end
    endcase
  end

  assign res.ok             = ok;
  assign res.element        = elem_r;
  assign res.found_position = found;
  assign res.length         = count;
  assign res.empty_res      = (count == '0);

  a_slot_books: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} + {1'b0, ftop}) == {1'b0, fill})
    else $error("slot bookkeeping out of step with element count");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CB'(ple_pkg::CAPACITY))
    else $error("element count above capacity");

  a_hop_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.hop |-> idx < count)
    else $error("link walk past the end of the list");

endmodule

`default_nettype wire

FILE: sv/positional_list_engine.sv
// insert, delete and get walk the links up to the command position, locate walks until a
//   match or the list end, clear and insert at the head do not walk
// throughput: one command at a time, the next word is taken in the cycle after the result
//   is loaded; the link walk sets the rate, one link per cycle through the link memory read
// reset: synchronous, empties the list at once; element and link memories are not cleared
`default_nettype none

module positional_list_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire ple_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ple_pkg::rsp_t      rsp
);

  ple_pkg::ctrl_t   ctrl;
  ple_pkg::status_t status;
  ple_pkg::rsp_t    res;
  logic             idle;
  logic             accept;
  logic             out_free;

  assign cmd_stall = !idle;
  assign accept    = cmd_valid && idle;
  assign out_free  = !rsp_valid || !rsp_stall;

  ple_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd_valid),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl),
    .idle     (idle)
  );

  ple_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .ctrl   (ctrl),
    .status (status),
    .res    (res)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.op == ple_pkg::OP_EMIT) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == ple_pkg::OP_EMIT) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire
